// ----- hw/rtl/fpb_pkg.sv -----
// ============================================================================
// fpb_pkg
// Shared types, constants and the microcode store of the fisheye point
// back-projection block.
// ============================================================================
package fpb_pkg;

    // Newton iteration limit and the width of its counter
    localparam int NEWTON_STEPS = 10;
    localparam int ITER_W       = $clog2(NEWTON_STEPS + 1);

    // Microcode addressing
    localparam int PC_W = 7;
    localparam logic [PC_W-1:0] LOOP_PC = 7'd15;
    localparam logic [PC_W-1:0] END_PC  = 7'd69;

    // Fixed-point constants (signed Q.30 in 64 bits)
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q62_LIMIT   = 64'h4000_0000_0000_0000;
    localparam logic [63:0] STEP_MAX    = 64'h0000_0001_0000_0000;
    localparam logic [63:0] COORD_MAX   = 64'd2147483647;

    // Configuration register indexes
    localparam logic [2:0] CFG_FOCAL_X  = 3'd0;
    localparam logic [2:0] CFG_FOCAL_Y  = 3'd1;
    localparam logic [2:0] CFG_CENTER_X = 3'd2;
    localparam logic [2:0] CFG_CENTER_Y = 3'd3;
    localparam logic [2:0] CFG_COEFF_1  = 3'd4;
    localparam logic [2:0] CFG_COEFF_2  = 3'd5;
    localparam logic [2:0] CFG_COEFF_3  = 3'd6;
    localparam logic [2:0] CFG_COEFF_4  = 3'd7;

    // Register file depth and entries
    localparam int RF_DEPTH = 24;
    localparam logic [5:0] R_X     = 6'd0;
    localparam logic [5:0] R_Y     = 6'd1;
    localparam logic [5:0] R_Z     = 6'd2;
    localparam logic [5:0] R_NX    = 6'd3;
    localparam logic [5:0] R_NY    = 6'd4;
    localparam logic [5:0] R_SQ    = 6'd5;
    localparam logic [5:0] R_SQ2   = 6'd6;
    localparam logic [5:0] R_TD    = 6'd7;
    localparam logic [5:0] R_T     = 6'd8;
    localparam logic [5:0] R_U     = 6'd9;
    localparam logic [5:0] R_F     = 6'd10;
    localparam logic [5:0] R_DF    = 6'd11;
    localparam logic [5:0] R_NUM   = 6'd12;
    localparam logic [5:0] R_STEP  = 6'd13;
    localparam logic [5:0] R_S     = 6'd14;
    localparam logic [5:0] R_C     = 6'd15;
    localparam logic [5:0] R_SN    = 6'd16;
    localparam logic [5:0] R_CS    = 6'd17;
    localparam logic [5:0] R_RX    = 6'd18;
    localparam logic [5:0] R_RY    = 6'd19;
    localparam logic [5:0] R_K1X3  = 6'd20;
    localparam logic [5:0] R_K2X5  = 6'd21;
    localparam logic [5:0] R_K3X7  = 6'd22;
    localparam logic [5:0] R_K4X9  = 6'd23;

    // Constant operand sources (top bit set)
    localparam logic [5:0] S_K1     = 6'd32;
    localparam logic [5:0] S_K2     = 6'd33;
    localparam logic [5:0] S_K3     = 6'd34;
    localparam logic [5:0] S_K4     = 6'd35;
    localparam logic [5:0] S_RANGE  = 6'd36;
    localparam logic [5:0] S_ONE    = 6'd37;
    localparam logic [5:0] S_ZERO   = 6'd38;
    localparam logic [5:0] S_S27    = 6'd39;
    localparam logic [5:0] S_S2959  = 6'd40;
    localparam logic [5:0] S_S213K  = 6'd41;
    localparam logic [5:0] S_S8947K = 6'd42;
    localparam logic [5:0] S_S1789K = 6'd43;
    localparam logic [5:0] S_C2     = 6'd44;
    localparam logic [5:0] S_C296   = 6'd45;
    localparam logic [5:0] S_C26631 = 6'd46;
    localparam logic [5:0] S_C1491K = 6'd47;
    localparam logic [5:0] S_C4473K = 6'd48;
    localparam logic [5:0] S_CHALF  = 6'd49;
    localparam logic [5:0] S_N3     = 6'd50;
    localparam logic [5:0] S_N5     = 6'd51;
    localparam logic [5:0] S_N7     = 6'd52;
    localparam logic [5:0] S_N9     = 6'd53;

    // Micro-operations
    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_ADDCL, OP_MUL, OP_MULR, OP_DIV, OP_NORMX,
        OP_NORMY, OP_SQRT, OP_SATT, OP_BTDZ, OP_LOOP, OP_END
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [5:0] dst;
        logic [5:0] srca;
        logic [5:0] srcb;
    } uop_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       take;
        logic       rd;
        logic       ex;
        logic       load_out;
        op_t        op;
        logic [4:0] dst;
        logic [5:0] srca;
        logic [5:0] srcb;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic done;
        logic td_zero;
        logic step_small;
        logic out_busy;
    } sts_t;

    function automatic logic [63:0] mag64(input logic [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

    function automatic uop_t mk(input op_t op, input logic [5:0] dst,
                                input logic [5:0] srca, input logic [5:0] srcb);
        uop_t u;
        u.op   = op;
        u.dst  = dst;
        u.srca = srca;
        u.srcb = srcb;
        return u;
    endfunction

    // Microcode program
    function automatic uop_t ucode(input logic [PC_W-1:0] pc);
        uop_t u;
        u = mk(OP_END, R_X, S_ZERO, S_ZERO);
        case (pc)
            7'd0:  u = mk(OP_ADD,   R_X,    S_ZERO,   S_ZERO);
            7'd1:  u = mk(OP_ADD,   R_Y,    S_ZERO,   S_ZERO);
            7'd2:  u = mk(OP_ADD,   R_Z,    S_RANGE,  S_ZERO);
            7'd3:  u = mk(OP_NORMX, R_NX,   S_ZERO,   S_ZERO);
            7'd4:  u = mk(OP_NORMY, R_NY,   S_ZERO,   S_ZERO);
            7'd5:  u = mk(OP_MULR,  R_SQ,   R_NX,     R_NX);
            7'd6:  u = mk(OP_MULR,  R_SQ2,  R_NY,     R_NY);
            7'd7:  u = mk(OP_ADD,   R_SQ,   R_SQ,     R_SQ2);
            7'd8:  u = mk(OP_SQRT,  R_TD,   R_SQ,     S_ZERO);
            7'd9:  u = mk(OP_BTDZ,  R_X,    S_ZERO,   S_ZERO);
            7'd10: u = mk(OP_ADDCL, R_T,    R_TD,     S_ZERO);
            7'd11: u = mk(OP_MULR,  R_K1X3, S_K1,     S_N3);
            7'd12: u = mk(OP_MULR,  R_K2X5, S_K2,     S_N5);
            7'd13: u = mk(OP_MULR,  R_K3X7, S_K3,     S_N7);
            7'd14: u = mk(OP_MULR,  R_K4X9, S_K4,     S_N9);
            // Newton loop
            7'd15: u = mk(OP_MUL,   R_U,    R_T,      R_T);
            7'd16: u = mk(OP_MUL,   R_F,    R_U,      S_K4);
            7'd17: u = mk(OP_ADD,   R_F,    S_K3,     R_F);
            7'd18: u = mk(OP_MUL,   R_F,    R_U,      R_F);
            7'd19: u = mk(OP_ADD,   R_F,    S_K2,     R_F);
            7'd20: u = mk(OP_MUL,   R_F,    R_U,      R_F);
            7'd21: u = mk(OP_ADD,   R_F,    S_K1,     R_F);
            7'd22: u = mk(OP_MUL,   R_F,    R_U,      R_F);
            7'd23: u = mk(OP_ADD,   R_F,    S_ONE,    R_F);
            7'd24: u = mk(OP_MUL,   R_F,    R_T,      R_F);
            7'd25: u = mk(OP_MUL,   R_DF,   R_U,      R_K4X9);
            7'd26: u = mk(OP_ADD,   R_DF,   R_K3X7,   R_DF);
            7'd27: u = mk(OP_MUL,   R_DF,   R_U,      R_DF);
            7'd28: u = mk(OP_ADD,   R_DF,   R_K2X5,   R_DF);
            7'd29: u = mk(OP_MUL,   R_DF,   R_U,      R_DF);
            7'd30: u = mk(OP_ADD,   R_DF,   R_K1X3,   R_DF);
            7'd31: u = mk(OP_MUL,   R_DF,   R_U,      R_DF);
            7'd32: u = mk(OP_ADD,   R_DF,   S_ONE,    R_DF);
            7'd33: u = mk(OP_SUB,   R_NUM,  R_TD,     R_F);
            7'd34: u = mk(OP_DIV,   R_STEP, R_NUM,    R_DF);
            7'd35: u = mk(OP_ADDCL, R_T,    R_T,      R_STEP);
            7'd36: u = mk(OP_LOOP,  R_X,    S_ZERO,   S_ZERO);
            // Sine and cosine polynomials
            7'd37: u = mk(OP_SATT,  R_X,    R_T,      S_ZERO);
            7'd38: u = mk(OP_MUL,   R_U,    R_T,      R_T);
            7'd39: u = mk(OP_MUL,   R_S,    R_U,      S_S27);
            7'd40: u = mk(OP_SUB,   R_S,    S_S2959,  R_S);
            7'd41: u = mk(OP_MUL,   R_S,    R_U,      R_S);
            7'd42: u = mk(OP_SUB,   R_S,    S_S213K,  R_S);
            7'd43: u = mk(OP_MUL,   R_S,    R_U,      R_S);
            7'd44: u = mk(OP_SUB,   R_S,    S_S8947K, R_S);
            7'd45: u = mk(OP_MUL,   R_S,    R_U,      R_S);
            7'd46: u = mk(OP_SUB,   R_S,    S_S1789K, R_S);
            7'd47: u = mk(OP_MUL,   R_S,    R_U,      R_S);
            7'd48: u = mk(OP_SUB,   R_S,    S_ONE,    R_S);
            7'd49: u = mk(OP_MUL,   R_SN,   R_T,      R_S);
            7'd50: u = mk(OP_MUL,   R_C,    R_U,      S_C2);
            7'd51: u = mk(OP_SUB,   R_C,    S_C296,   R_C);
            7'd52: u = mk(OP_MUL,   R_C,    R_U,      R_C);
            7'd53: u = mk(OP_SUB,   R_C,    S_C26631, R_C);
            7'd54: u = mk(OP_MUL,   R_C,    R_U,      R_C);
            7'd55: u = mk(OP_SUB,   R_C,    S_C1491K, R_C);
            7'd56: u = mk(OP_MUL,   R_C,    R_U,      R_C);
            7'd57: u = mk(OP_SUB,   R_C,    S_C4473K, R_C);
            7'd58: u = mk(OP_MUL,   R_C,    R_U,      R_C);
            7'd59: u = mk(OP_SUB,   R_C,    S_CHALF,  R_C);
            7'd60: u = mk(OP_MUL,   R_C,    R_U,      R_C);
            7'd61: u = mk(OP_SUB,   R_CS,   S_ONE,    R_C);
            // Direction and scaling to the range
            7'd62: u = mk(OP_DIV,   R_RX,   R_NX,     R_TD);
            7'd63: u = mk(OP_DIV,   R_RY,   R_NY,     R_TD);
            7'd64: u = mk(OP_MUL,   R_X,    R_RX,     R_SN);
            7'd65: u = mk(OP_MUL,   R_X,    R_X,      S_RANGE);
            7'd66: u = mk(OP_MUL,   R_Y,    R_RY,     R_SN);
            7'd67: u = mk(OP_MUL,   R_Y,    R_Y,      S_RANGE);
            7'd68: u = mk(OP_MUL,   R_Z,    R_CS,     S_RANGE);
            default: u = mk(OP_END, R_X,    S_ZERO,   S_ZERO);
        endcase
        return u;
    endfunction

endpackage

// ----- hw/rtl/fisheye_point_backprojection.sv -----
// The centre pixel skips the Newton loop; other pixels run 1 to 10 Newton steps,
// and each division that ends early is shorter. The run time is set by the shared
// 64-bit multiplier and the shared divider.
// Throughput: one item at a time; the next beat can be taken in the cycle after the
// previous result is loaded into the output register.
// Reset: synchronous, active low; clears control state and loads the defaults.
// ============================================================================
// fisheye_point_backprojection
// Turns a pixel position and a distance into a camera-frame point by
// inverting the odd-polynomial fisheye model with Newton steps.
// ============================================================================
module fisheye_point_backprojection (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,      // pixel_x, pixel_y, range_to_point
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,      // cam_x, cam_y, cam_z
    output logic        m_tuser,      // saturated
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_index,
    input  logic [31:0] cfg_wr_data
);

    logic [19:0] focal_x_reg;
    logic [19:0] focal_y_reg;
    logic [15:0] center_x_reg;
    logic [15:0] center_y_reg;
    logic [31:0] coeff_one_reg;
    logic [31:0] coeff_two_reg;
    logic [31:0] coeff_three_reg;
    logic [31:0] coeff_four_reg;

    fpb_pkg::cmd_t cmd;
    fpb_pkg::sts_t sts;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg     <= 20'd18074;
            focal_y_reg     <= 20'd18074;
            center_x_reg    <= 16'd1272;
            center_y_reg    <= 16'd964;
            coeff_one_reg   <= 32'd7793308;
            coeff_two_reg   <= 32'hFFD8_7FE6;
            coeff_three_reg <= 32'd4284897;
            coeff_four_reg  <= 32'hFFE7_BC53;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                fpb_pkg::CFG_FOCAL_X:  focal_x_reg     <= cfg_wr_data[19:0];
                fpb_pkg::CFG_FOCAL_Y:  focal_y_reg     <= cfg_wr_data[19:0];
                fpb_pkg::CFG_CENTER_X: center_x_reg    <= cfg_wr_data[15:0];
                fpb_pkg::CFG_CENTER_Y: center_y_reg    <= cfg_wr_data[15:0];
                fpb_pkg::CFG_COEFF_1:  coeff_one_reg   <= cfg_wr_data;
                fpb_pkg::CFG_COEFF_2:  coeff_two_reg   <= cfg_wr_data;
                fpb_pkg::CFG_COEFF_3:  coeff_three_reg <= cfg_wr_data;
                fpb_pkg::CFG_COEFF_4:  coeff_four_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    fpb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    fpb_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .pixel_x        (s_tdata[15:0]),
        .pixel_y        (s_tdata[31:16]),
        .range_to_point (s_tdata[47:32]),
        .focal_x        (focal_x_reg),
        .focal_y        (focal_y_reg),
        .center_x       (center_x_reg),
        .center_y       (center_y_reg),
        .coeff_one      (coeff_one_reg),
        .coeff_two      (coeff_two_reg),
        .coeff_three    (coeff_three_reg),
        .coeff_four     (coeff_four_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .cam_x          (m_tdata[15:0]),
        .cam_y          (m_tdata[31:16]),
        .cam_z          (m_tdata[47:32]),
        .saturated      (m_tuser)
    );

endmodule

// ----- hw/rtl/fpb_mul.sv -----
// ============================================================================
// fpb_mul
// Multi-cycle 64x64 sign-magnitude multiplier built on one 32x32 unit.
// Gives either the Q.30 product (truncated, limited to 2^62) or the raw
// low 64 bits of the product.
// ============================================================================
module fpb_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic        raw,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] res
);

    localparam logic [63:0] Q62_LIMIT_L = fpb_pkg::Q62_LIMIT;

    logic         busy_reg;
    logic [2:0]   cnt_reg;
    logic [63:0]  ua_reg;
    logic [63:0]  ub_reg;
    logic         neg_reg;
    logic         raw_reg;
    logic [63:0]  pp_reg;
    logic [127:0] acc_reg;
    logic         done_reg;
    logic [63:0]  res_reg;

    logic [31:0]  ha;
    logic [31:0]  hb;
    logic [63:0]  pp_next;
    logic [127:0] pp_shift;
    logic [63:0]  rq;
    logic [63:0]  rsel;

    // Partial product selection: (lo,lo) (lo,hi) (hi,lo) (hi,hi)
    always_comb begin
        ha = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
        hb = cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
        pp_next = {32'd0, ha} * {32'd0, hb};
    end

    // Weight of the partial product being accumulated
    always_comb begin
        case (cnt_reg)
            3'd1:    pp_shift = {64'd0, pp_reg};
            3'd2:    pp_shift = {32'd0, pp_reg, 32'd0};
            3'd3:    pp_shift = {32'd0, pp_reg, 32'd0};
            3'd4:    pp_shift = {pp_reg, 64'd0};
            default: pp_shift = 128'd0;
        endcase
    end

    // Final scaling and sign
    always_comb begin
        if (|acc_reg[127:92]) begin
            rq = Q62_LIMIT_L;
        end else begin
            rq = {2'b00, acc_reg[91:30]};
        end
        if (rq > Q62_LIMIT_L) begin
            rq = Q62_LIMIT_L;
        end
        rsel = raw_reg ? acc_reg[63:0] : rq;
    end

    // Sequencing of the four partial products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end else if (busy_reg) begin
                if (cnt_reg == 3'd5) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
        end
    end

    // Operand, product and accumulator registers
    always_ff @(posedge aclk) begin
        if (start) begin
            ua_reg  <= fpb_pkg::mag64(a);
            ub_reg  <= fpb_pkg::mag64(b);
            neg_reg <= a[63] ^ b[63];
            raw_reg <= raw;
            acc_reg <= 128'd0;
        end else if (busy_reg) begin
            pp_reg  <= pp_next;
            acc_reg <= acc_reg + pp_shift;
            if (cnt_reg == 3'd5) begin
                res_reg <= neg_reg ? (64'd0 - rsel) : rsel;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ----- hw/rtl/fpb_divsqrt.sv -----
// ============================================================================
// fpb_divsqrt
// Shared shift-and-subtract unit: one quotient or root bit per cycle.
// Division gives (n * 2^30) / d limited to 2^32; the root is the integer
// square root of a 64-bit value.
// ============================================================================
module fpb_divsqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic        sqrt_mode,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] res
);

    logic        busy_reg;
    logic        mode_reg;
    logic [4:0]  cnt_reg;
    logic [65:0] rem_reg;
    logic [65:0] den_reg;
    logic [63:0] quo_reg;
    logic [63:0] sbit_reg;
    logic        done_reg;

    logic [65:0] trial;
    logic [65:0] shifted;
    logic [65:0] root_try;
    logic        fast_zero;
    logic        fast_max;

    // Early outcomes of a division
    always_comb begin
        fast_zero = (den == 64'd0);
        fast_max  = ({2'b00, num} >= {den, 2'b00});
    end

    // One step of either algorithm
    always_comb begin
        trial    = (cnt_reg == 5'd0) ? {den_reg[64:0], 1'b0} : den_reg;
        shifted  = (cnt_reg <= 5'd1) ? rem_reg : {rem_reg[64:0], 1'b0};
        root_try = {2'b00, quo_reg} + {2'b00, sbit_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= 5'd0;
                if (!sqrt_mode && (fast_zero || fast_max)) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder, divisor and result registers
    always_ff @(posedge aclk) begin
        if (start) begin
            mode_reg <= sqrt_mode;
            rem_reg  <= {2'b00, num};
            den_reg  <= {2'b00, den};
            sbit_reg <= 64'h4000_0000_0000_0000;
            if (!sqrt_mode && fast_zero) begin
                quo_reg <= 64'd0;
            end else if (!sqrt_mode && fast_max) begin
                quo_reg <= fpb_pkg::STEP_MAX;
            end else begin
                quo_reg <= 64'd0;
            end
        end else if (busy_reg) begin
            if (mode_reg) begin
                sbit_reg <= {2'b00, sbit_reg[63:2]};
                if (rem_reg >= root_try) begin
                    rem_reg <= rem_reg - root_try;
                    quo_reg <= {1'b0, quo_reg[63:1]} + sbit_reg;
                end else begin
                    quo_reg <= {1'b0, quo_reg[63:1]};
                end
            end else begin
                if (shifted >= trial) begin
                    rem_reg <= shifted - trial;
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= shifted;
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
            end
        end
    end

    assign done = done_reg;
    assign res  = quo_reg;

endmodule

// ----- hw/rtl/fpb_dp.sv -----
// ============================================================================
// fpb_dp
// Datapath: register file, adder, angle clamp, multiplier and divider
// units, and the output register with field saturation.
// ============================================================================
module fpb_dp (
    input  logic            aclk,
    input  logic            aresetn,
    input  fpb_pkg::cmd_t   cmd,
    output fpb_pkg::sts_t   sts,
    input  logic [15:0]     pixel_x,
    input  logic [15:0]     pixel_y,
    input  logic [15:0]     range_to_point,
    input  logic [19:0]     focal_x,
    input  logic [19:0]     focal_y,
    input  logic [15:0]     center_x,
    input  logic [15:0]     center_y,
    input  logic [31:0]     coeff_one,
    input  logic [31:0]     coeff_two,
    input  logic [31:0]     coeff_three,
    input  logic [31:0]     coeff_four,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [15:0]     cam_x,
    output logic [15:0]     cam_y,
    output logic [15:0]     cam_z,
    output logic            saturated
);

    logic [63:0] rf [0:fpb_pkg::RF_DEPTH-1];

    logic [15:0] px_reg;
    logic [15:0] py_reg;
    logic [15:0] rng_reg;
    logic [63:0] opa_reg;
    logic [63:0] opb_reg;
    fpb_pkg::op_t op_reg;
    logic [4:0]  dst_reg;
    logic        neg_reg;
    logic        done_reg;
    logic        sat_reg;
    logic        td_zero_reg;
    logic        step_small_reg;
    logic [63:0] x_reg;
    logic [63:0] y_reg;
    logic [63:0] z_reg;
    logic        out_valid_reg;
    logic [15:0] cam_x_reg;
    logic [15:0] cam_y_reg;
    logic [15:0] cam_z_reg;
    logic        saturated_reg;

    logic [63:0] src_a;
    logic [63:0] src_b;
    logic [63:0] sum;
    logic [63:0] alu;
    logic        simple_wr;
    logic [16:0] dx;
    logic [16:0] dy;
    logic [16:0] magd;
    logic [19:0] focal;
    logic        mul_start;
    logic        mul_done;
    logic [63:0] mul_res;
    logic        div_start;
    logic        div_sqrt;
    logic [63:0] div_num;
    logic [63:0] div_den;
    logic        div_done;
    logic [63:0] div_res;
    logic [63:0] norm_clip;
    logic        norm_sat;
    logic        wr_en;
    logic [4:0]  wr_addr;
    logic [63:0] wr_data;
    logic [16:0] fx;
    logic [16:0] fy;
    logic [16:0] fz;

    function automatic logic [63:0] const_val(
        input logic [5:0]  src,
        input logic [31:0] k1,
        input logic [31:0] k2,
        input logic [31:0] k3,
        input logic [31:0] k4,
        input logic [15:0] rng
    );
        logic [63:0] v;
        case (src)
            fpb_pkg::S_K1:     v = {{32{k1[31]}}, k1};
            fpb_pkg::S_K2:     v = {{32{k2[31]}}, k2};
            fpb_pkg::S_K3:     v = {{32{k3[31]}}, k3};
            fpb_pkg::S_K4:     v = {{32{k4[31]}}, k4};
            fpb_pkg::S_RANGE:  v = {48'd0, rng};
            fpb_pkg::S_ONE:    v = fpb_pkg::ONE_Q30;
            fpb_pkg::S_S27:    v = 64'd27;
            fpb_pkg::S_S2959:  v = 64'd2959;
            fpb_pkg::S_S213K:  v = 64'd213044;
            fpb_pkg::S_S8947K: v = 64'd8947849;
            fpb_pkg::S_S1789K: v = 64'd178956971;
            fpb_pkg::S_C2:     v = 64'd2;
            fpb_pkg::S_C296:   v = 64'd296;
            fpb_pkg::S_C26631: v = 64'd26631;
            fpb_pkg::S_C1491K: v = 64'd1491308;
            fpb_pkg::S_C4473K: v = 64'd44739243;
            fpb_pkg::S_CHALF:  v = 64'd536870912;
            fpb_pkg::S_N3:     v = 64'd3;
            fpb_pkg::S_N5:     v = 64'd5;
            fpb_pkg::S_N7:     v = 64'd7;
            fpb_pkg::S_N9:     v = 64'd9;
            default:           v = 64'd0;
        endcase
        return v;
    endfunction

    // Clip a signed value to a 16-bit field; bit 16 flags clipping
    function automatic logic [16:0] to_field(input logic [63:0] v);
        logic [16:0] r;
        if (!v[63] && (v > 64'd32767)) begin
            r = {1'b1, 16'h7FFF};
        end else if (v[63] && ($signed(v) < -64'sd32768)) begin
            r = {1'b1, 16'h8000};
        end else begin
            r = {1'b0, v[15:0]};
        end
        return r;
    endfunction

    // Operand selection for the registered read
    always_comb begin
        src_a = cmd.srca[5] ? const_val(cmd.srca, coeff_one, coeff_two, coeff_three,
                                        coeff_four, rng_reg)
                            : rf[cmd.srca[4:0]];
        src_b = cmd.srcb[5] ? const_val(cmd.srcb, coeff_one, coeff_two, coeff_three,
                                        coeff_four, rng_reg)
                            : rf[cmd.srcb[4:0]];
    end

    // Adder and angle clamp
    always_comb begin
        sum = opa_reg + opb_reg;
        case (cmd.op)
            fpb_pkg::OP_SUB: alu = opa_reg - opb_reg;
            fpb_pkg::OP_ADDCL: begin
                if (!sum[63] && (sum > fpb_pkg::HALF_PI_Q30)) begin
                    alu = fpb_pkg::HALF_PI_Q30;
                end else if (sum[63] && ((64'd0 - sum) > fpb_pkg::HALF_PI_Q30)) begin
                    alu = 64'd0 - fpb_pkg::HALF_PI_Q30;
                end else begin
                    alu = sum;
                end
            end
            default: alu = sum;
        endcase
        simple_wr = cmd.ex && ((cmd.op == fpb_pkg::OP_ADD) || (cmd.op == fpb_pkg::OP_SUB)
                               || (cmd.op == fpb_pkg::OP_ADDCL));
    end

    // Pixel offsets from the principal point
    always_comb begin
        dx = {1'b0, px_reg} - {1'b0, center_x};
        dy = {1'b0, py_reg} - {1'b0, center_y};
        if (cmd.op == fpb_pkg::OP_NORMY) begin
            magd  = dy[16] ? (17'd0 - dy) : dy;
            focal = (focal_y == 20'd0) ? 20'd1 : focal_y;
        end else begin
            magd  = dx[16] ? (17'd0 - dx) : dx;
            focal = (focal_x == 20'd0) ? 20'd1 : focal_x;
        end
    end

    // Unit launch
    always_comb begin
        mul_start = cmd.ex && ((cmd.op == fpb_pkg::OP_MUL) || (cmd.op == fpb_pkg::OP_MULR));
        div_start = cmd.ex && ((cmd.op == fpb_pkg::OP_DIV) || (cmd.op == fpb_pkg::OP_NORMX)
                               || (cmd.op == fpb_pkg::OP_NORMY)
                               || (cmd.op == fpb_pkg::OP_SQRT));
        div_sqrt  = (cmd.op == fpb_pkg::OP_SQRT);
        case (cmd.op)
            fpb_pkg::OP_NORMX, fpb_pkg::OP_NORMY: begin
                div_num = {44'd0, magd[15:0], 4'd0};
                div_den = {44'd0, focal};
            end
            fpb_pkg::OP_SQRT: begin
                div_num = opa_reg;
                div_den = 64'd1;
            end
            default: begin
                div_num = fpb_pkg::mag64(opa_reg);
                div_den = fpb_pkg::mag64(opb_reg);
            end
        endcase
    end

    fpb_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .raw     (cmd.op == fpb_pkg::OP_MULR),
        .a       (opa_reg),
        .b       (opb_reg),
        .done    (mul_done),
        .res     (mul_res)
    );

    fpb_divsqrt u_divsqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .sqrt_mode (div_sqrt),
        .num       (div_num),
        .den       (div_den),
        .done      (div_done),
        .res       (div_res)
    );

    // Result writeback
    always_comb begin
        norm_sat  = (div_res > fpb_pkg::COORD_MAX);
        norm_clip = norm_sat ? fpb_pkg::COORD_MAX : div_res;
        wr_en   = 1'b0;
        wr_addr = dst_reg;
        wr_data = 64'd0;
        if (simple_wr) begin
            wr_en   = 1'b1;
            wr_addr = cmd.dst;
            wr_data = alu;
        end else if (mul_done) begin
            wr_en   = 1'b1;
            wr_data = mul_res;
        end else if (div_done) begin
            wr_en = 1'b1;
            case (op_reg)
                fpb_pkg::OP_SQRT: wr_data = div_res;
                fpb_pkg::OP_NORMX, fpb_pkg::OP_NORMY:
                    wr_data = neg_reg ? (64'd0 - norm_clip) : norm_clip;
                default: wr_data = neg_reg ? (64'd0 - div_res) : div_res;
            endcase
        end
    end

    // Register file
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rf[wr_addr] <= wr_data;
        end
        if (cmd.rd) begin
            opa_reg <= src_a;
            opb_reg <= src_b;
        end
    end

    // Item capture, operation bookkeeping and result shadows
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            px_reg  <= pixel_x;
            py_reg  <= pixel_y;
            rng_reg <= range_to_point;
        end
        if (cmd.ex) begin
            op_reg  <= cmd.op;
            dst_reg <= cmd.dst;
            if ((cmd.op == fpb_pkg::OP_NORMX)) begin
                neg_reg <= dx[16];
            end else if (cmd.op == fpb_pkg::OP_NORMY) begin
                neg_reg <= dy[16];
            end else begin
                neg_reg <= opa_reg[63] ^ opb_reg[63];
            end
        end
        if (wr_en) begin
            if (wr_addr == fpb_pkg::R_TD[4:0]) begin
                td_zero_reg <= (wr_data == 64'd0);
            end
            if (wr_addr == fpb_pkg::R_STEP[4:0]) begin
                step_small_reg <= (fpb_pkg::mag64(wr_data) <= 64'd1);
            end
            if (wr_addr == fpb_pkg::R_X[4:0]) begin
                x_reg <= wr_data;
            end
            if (wr_addr == fpb_pkg::R_Y[4:0]) begin
                y_reg <= wr_data;
            end
            if (wr_addr == fpb_pkg::R_Z[4:0]) begin
                z_reg <= wr_data;
            end
        end
    end

    // Control flags: completion of adder and angle-check operations, and saturation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
        end else begin
            done_reg <= simple_wr || (cmd.ex && (cmd.op == fpb_pkg::OP_SATT));
            if (cmd.take) begin
                sat_reg <= 1'b0;
            end else if (div_done && norm_sat && ((op_reg == fpb_pkg::OP_NORMX)
                                               || (op_reg == fpb_pkg::OP_NORMY))) begin
                sat_reg <= 1'b1;
            end else if (cmd.ex && (cmd.op == fpb_pkg::OP_SATT)
                         && ((opa_reg == fpb_pkg::HALF_PI_Q30)
                             || (opa_reg == (64'd0 - fpb_pkg::HALF_PI_Q30)))) begin
                sat_reg <= 1'b1;
            end
        end
    end

    // Output register
    always_comb begin
        fx = to_field(x_reg);
        fy = to_field(y_reg);
        fz = to_field(z_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            cam_x_reg     <= fx[15:0];
            cam_y_reg     <= fy[15:0];
            cam_z_reg     <= fz[15:0];
            saturated_reg <= sat_reg | fx[16] | fy[16] | fz[16];
        end
    end

    assign sts.done       = done_reg | mul_done | div_done;
    assign sts.td_zero    = td_zero_reg;
    assign sts.step_small = step_small_reg;
    assign sts.out_busy   = out_valid_reg & ~out_ready;

    assign out_valid = out_valid_reg;
    assign cam_x     = cam_x_reg;
    assign cam_y     = cam_y_reg;
    assign cam_z     = cam_z_reg;
    assign saturated = saturated_reg;

endmodule

// ----- hw/rtl/fpb_ctrl.sv -----
// ============================================================================
// fpb_ctrl
// Controller: microcode sequencer that fetches operations, issues them to
// the datapath, runs the Newton loop and hands the result to the output.
// ============================================================================
module fpb_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    output fpb_pkg::cmd_t cmd,
    input  fpb_pkg::sts_t sts
);

    typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_EXEC, ST_WAIT} state_t;

    state_t                      state_reg;
    logic [fpb_pkg::PC_W-1:0]    pc_reg;
    logic [fpb_pkg::ITER_W-1:0]  iter_reg;
    fpb_pkg::uop_t               uop;
    logic                        is_ctl;

    // Current micro-operation
    always_comb begin
        uop    = fpb_pkg::ucode(pc_reg);
        is_ctl = (uop.op == fpb_pkg::OP_BTDZ) || (uop.op == fpb_pkg::OP_LOOP)
                 || (uop.op == fpb_pkg::OP_END);
    end

    // Commands to the datapath
    always_comb begin
        cmd.take     = in_valid && (state_reg == ST_IDLE);
        cmd.rd       = (state_reg == ST_FETCH) && !is_ctl;
        cmd.ex       = (state_reg == ST_EXEC);
        cmd.load_out = (state_reg == ST_FETCH) && (uop.op == fpb_pkg::OP_END)
                       && !sts.out_busy;
        cmd.op       = uop.op;
        cmd.dst      = uop.dst[4:0];
        cmd.srca     = uop.srca;
        cmd.srcb     = uop.srcb;
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            iter_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        state_reg <= ST_FETCH;
                        pc_reg    <= '0;
                        iter_reg  <= '0;
                    end
                end
                ST_FETCH: begin
                    case (uop.op)
                        fpb_pkg::OP_BTDZ: begin
                            pc_reg <= sts.td_zero ? fpb_pkg::END_PC
                                                  : pc_reg + fpb_pkg::PC_W'(1);
                        end
                        fpb_pkg::OP_LOOP: begin
                            if (sts.step_small
                                || (iter_reg == fpb_pkg::ITER_W'(fpb_pkg::NEWTON_STEPS - 1))) begin
                                pc_reg   <= pc_reg + fpb_pkg::PC_W'(1);
                                iter_reg <= '0;
                            end else begin
                                pc_reg   <= fpb_pkg::LOOP_PC;
                                iter_reg <= iter_reg + fpb_pkg::ITER_W'(1);
                            end
                        end
                        fpb_pkg::OP_END: begin
                            if (!sts.out_busy) begin
                                state_reg <= ST_IDLE;
                            end
                        end
                        default: state_reg <= ST_EXEC;
                    endcase
                end
                ST_EXEC: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (sts.done) begin
                        state_reg <= ST_FETCH;
                        pc_reg    <= pc_reg + fpb_pkg::PC_W'(1);
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// ============================================================================
// tb_top
// Self-checking bench for the fisheye point back-projection block. A directed
// table and then random pixels are streamed in under several calibration
// settings and idling patterns. Each output beat is compared field by field
// with a bit-exact fixed-point back-projection computed in the bench.
// ============================================================================
module tb_top;

    // Idling patterns and run limits
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_SEND   = 1;
    localparam int IDLE_RECV   = 2;
    localparam int IDLE_BOTH   = 3;
    localparam int ITEMS_PHASE = 220;
    localparam int DRAIN_WAIT  = 2200;
    localparam longint CYCLE_LIMIT = 64'd40_000_000;

    localparam longint ONE_Q  = 64'd1073741824;
    localparam longint HPI_Q  = 64'd1686629713;
    localparam longint LIM62  = 64'h4000_0000_0000_0000;
    localparam longint STEP_L = 64'h0000_0001_0000_0000;

    typedef struct packed {
        logic [15:0] cam_x;
        logic [15:0] cam_y;
        logic [15:0] cam_z;
        logic        sat;
    } cam_point_t;

    typedef struct {
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] rng;
        bit          pinned;
        cam_point_t  pt;
    } pixel_row_t;

    typedef struct {
        bit         pinned;
        cam_point_t pt;
    } pin_tag_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_wr_index = fpb_pkg::CFG_FOCAL_X;
    logic [31:0] cfg_wr_data = '0;

    // Calibration as the block currently holds it
    logic [19:0]        cal_fx, cal_fy;
    logic [15:0]        cal_cx, cal_cy;
    logic signed [31:0] cal_k1, cal_k2, cal_k3, cal_k4;

    cam_point_t  expected_points[$];
    pin_tag_t    pin_tags[$];
    pixel_row_t  dir_rows[$];
    int          idle_mode = IDLE_NONE;
    int          errors = 0;
    int          points_seen = 0;
    longint      cycles = 0;

    fisheye_point_backprojection u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Queue helpers: append at the tail
    // ------------------------------------------------------------------
    function automatic void queue_point(cam_point_t pt);
        expected_points.insert(expected_points.size(), pt);
    endfunction

    function automatic void queue_tag(pin_tag_t tag);
        pin_tags.insert(pin_tags.size(), tag);
    endfunction

    function automatic void queue_row(pixel_row_t row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // ------------------------------------------------------------------
    // Fixed-point back-projection
    // ------------------------------------------------------------------
    function automatic longint unsigned umag(longint a);
        return a < 0 ? 64'd0 - a : a;
    endfunction

    // Q.30 product truncated toward zero, magnitude held at 2^62.
    function automatic longint fx_mul(longint a, longint b);
        logic [127:0]    p;
        longint unsigned r;
        p = {64'd0, umag(a)} * {64'd0, umag(b)};
        if (p[127:92] != 0) r = LIM62;
        else r = p[93:30];
        if (r > LIM62) r = LIM62;
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    // Q.30 quotient of magnitudes, limited to 4.0.
    function automatic longint unsigned fx_div(longint unsigned n, longint unsigned d);
        logic [127:0] p;
        if (n >= 4 * d) return STEP_L;
        p = {34'd0, n, 30'd0} / {64'd0, d};
        return p[63:0];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint norm_coord(logic [15:0] pix, logic [15:0] cen,
                                          logic [19:0] f, inout bit sat);
        longint          d;
        longint unsigned q;
        d = longint'(pix) - longint'(cen);
        q = (umag(d) << 34) / (f == 0 ? 64'd1 : {44'd0, f});
        if (q > 64'd2147483647) begin
            q = 64'd2147483647;
            sat = 1'b1;
        end
        return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp_angle(longint t);
        if (t > HPI_Q) return HPI_Q;
        if (t < -HPI_Q) return -HPI_Q;
        return t;
    endfunction

    function automatic logic [15:0] clip_coord(longint v, inout bit sat);
        if (v > 32767) begin v = 32767; sat = 1'b1; end
        if (v < -32768) begin v = -32768; sat = 1'b1; end
        return v[15:0];
    endfunction

    function automatic cam_point_t backproject(logic [15:0] px, logic [15:0] py,
                                               logic [15:0] rng);
        longint k1, k2, k3, k4, r, nx, ny, x, y, z, tdq, t;
        longint u, s, c, sn, cs, rx, ry, f, df, num, stp;
        longint unsigned ax, ay, td, sm;
        bit          sat;
        cam_point_t  pt;
        k1 = cal_k1; k2 = cal_k2; k3 = cal_k3; k4 = cal_k4;
        sat = 1'b0;
        r  = rng;
        nx = norm_coord(px, cal_cx, cal_fx, sat);
        ny = norm_coord(py, cal_cy, cal_fy, sat);
        ax = umag(nx);
        ay = umag(ny);
        td = int_sqrt(ax * ax + ay * ay);
        x = 0; y = 0; z = r;
        if (td != 0) begin
            tdq = td;
            t = clamp_angle(tdq);
            // Newton inversion of the distortion polynomial
            for (int i = 0; i < fpb_pkg::NEWTON_STEPS; i++) begin
                u  = fx_mul(t, t);
                f  = k3 + fx_mul(u, k4);
                f  = k2 + fx_mul(u, f);
                f  = k1 + fx_mul(u, f);
                f  = ONE_Q + fx_mul(u, f);
                f  = fx_mul(t, f);
                df = 7 * k3 + fx_mul(u, 9 * k4);
                df = 5 * k2 + fx_mul(u, df);
                df = 3 * k1 + fx_mul(u, df);
                df = ONE_Q + fx_mul(u, df);
                num = tdq - f;
                if (df == 0) begin
                    stp = 0;
                end else begin
                    sm  = fx_div(umag(num), umag(df));
                    stp = ((num < 0) != (df < 0)) ? -longint'(sm) : longint'(sm);
                end
                t = clamp_angle(t + stp);
                if (umag(stp) <= 1) break;
            end
            if (t == HPI_Q || t == -HPI_Q) sat = 1'b1;

            // Taylor sine and cosine
            u  = fx_mul(t, t);
            s  = 2959 - fx_mul(u, 27);
            s  = 213044 - fx_mul(u, s);
            s  = 8947849 - fx_mul(u, s);
            s  = 178956971 - fx_mul(u, s);
            s  = ONE_Q - fx_mul(u, s);
            sn = fx_mul(t, s);
            c  = 296 - fx_mul(u, 2);
            c  = 26631 - fx_mul(u, c);
            c  = 1491308 - fx_mul(u, c);
            c  = 44739243 - fx_mul(u, c);
            c  = 536870912 - fx_mul(u, c);
            cs = ONE_Q - fx_mul(u, c);

            rx = fx_div(ax, td);
            ry = fx_div(ay, td);
            if (nx < 0) rx = -rx;
            if (ny < 0) ry = -ry;
            x = fx_mul(fx_mul(rx, sn), r);
            y = fx_mul(fx_mul(ry, sn), r);
            z = fx_mul(cs, r);
        end
        pt.cam_x = clip_coord(x, sat);
        pt.cam_y = clip_coord(y, sat);
        pt.cam_z = clip_coord(z, sat);
        pt.sat   = sat;
        return pt;
    endfunction

    // ------------------------------------------------------------------
    // Monitors: predict on input beats, check on output beats
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        pin_tag_t   tag;
        cam_point_t want, got;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d points outstanding", $time,
                     expected_points.size());
            $display("fisheye_point_backprojection: mismatch");
            $finish;
        end
        if (aresetn && s_tvalid && s_tready) begin
            tag = pin_tags.pop_front();
            if (tag.pinned) queue_point(tag.pt);
            else queue_point(backproject(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]));
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser};
            points_seen++;
            if (expected_points.size() == 0) begin
                errors++;
                $display("%0t: output beat with nothing expected: x=%0d y=%0d z=%0d sat=%0b",
                         $time, $signed(got.cam_x), $signed(got.cam_y),
                         $signed(got.cam_z), got.sat);
            end else begin
                want = expected_points.pop_front();
                if (want.cam_x !== got.cam_x) begin
                    errors++;
                    $display("%0t: cam_x expected %0d actual %0d", $time,
                             $signed(want.cam_x), $signed(got.cam_x));
                end
                if (want.cam_y !== got.cam_y) begin
                    errors++;
                    $display("%0t: cam_y expected %0d actual %0d", $time,
                             $signed(want.cam_y), $signed(got.cam_y));
                end
                if (want.cam_z !== got.cam_z) begin
                    errors++;
                    $display("%0t: cam_z expected %0d actual %0d", $time,
                             $signed(want.cam_z), $signed(got.cam_z));
                end
                if (want.sat !== got.sat) begin
                    errors++;
                    $display("%0t: saturated expected %0b actual %0b", $time,
                             want.sat, got.sat);
                end
            end
        end
    end

    // Receiver stalls, changed on the falling edge
    always @(negedge aclk) begin
        if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH)
            m_tready <= ($urandom_range(99) >= 53);
        else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic write_cal(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        case (idx)
            fpb_pkg::CFG_FOCAL_X:  cal_fx = val[19:0];
            fpb_pkg::CFG_FOCAL_Y:  cal_fy = val[19:0];
            fpb_pkg::CFG_CENTER_X: cal_cx = val[15:0];
            fpb_pkg::CFG_CENTER_Y: cal_cy = val[15:0];
            fpb_pkg::CFG_COEFF_1:  cal_k1 = val;
            fpb_pkg::CFG_COEFF_2:  cal_k2 = val;
            fpb_pkg::CFG_COEFF_3:  cal_k3 = val;
            default:               cal_k4 = val;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_cal(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx,
                            logic [31:0] cy, logic [31:0] k1, logic [31:0] k2,
                            logic [31:0] k3, logic [31:0] k4);
        write_cal(fpb_pkg::CFG_FOCAL_X, fx);
        write_cal(fpb_pkg::CFG_FOCAL_Y, fy);
        write_cal(fpb_pkg::CFG_CENTER_X, cx);
        write_cal(fpb_pkg::CFG_CENTER_Y, cy);
        write_cal(fpb_pkg::CFG_COEFF_1, k1);
        write_cal(fpb_pkg::CFG_COEFF_2, k2);
        write_cal(fpb_pkg::CFG_COEFF_3, k3);
        write_cal(fpb_pkg::CFG_COEFF_4, k4);
    endtask

    // One input beat; the caller is at a falling edge.
    task automatic send_pixel(pixel_row_t row);
        pin_tag_t tag;
        if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) begin
            while ($urandom_range(99) < 53) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        tag.pinned = row.pinned;
        tag.pt     = row.pt;
        queue_tag(tag);
        s_tvalid <= 1'b1;
        s_tdata  <= {row.rng, row.py, row.px};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Drop valid right away, then wait for every result to come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (expected_points.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    function automatic void add_row(logic [15:0] px, logic [15:0] py, logic [15:0] rng,
                                    bit pinned, logic [15:0] ex, logic [15:0] ey,
                                    logic [15:0] ez, bit es);
        pixel_row_t row;
        row.px = px; row.py = py; row.rng = rng; row.pinned = pinned;
        row.pt = '{ex, ey, ez, es};
        queue_row(row);
    endfunction

    // Mostly pixels around the principal point, some anywhere in the field.
    function automatic pixel_row_t random_pixel(int spread);
        pixel_row_t row;
        int v;
        row.pinned = 1'b0;
        row.pt = '0;
        if ($urandom_range(9) < 7) begin
            v = int'(cal_cx) + $urandom_range(2 * spread) - spread;
            row.px = v < 0 ? 16'd0 : (v > 65535 ? 16'hFFFF : v[15:0]);
            v = int'(cal_cy) + $urandom_range(2 * spread) - spread;
            row.py = v < 0 ? 16'd0 : (v > 65535 ? 16'hFFFF : v[15:0]);
        end else begin
            row.px = 16'($urandom);
            row.py = 16'($urandom);
        end
        row.rng = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4095));
        return row;
    endfunction

    task automatic run_random(int count, int spread);
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) idle_mode = (i / 60) % 4;
            send_pixel(random_pixel(spread));
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        cal_fx = 20'd18074; cal_fy = 20'd18074;
        cal_cx = 16'd1272;  cal_cy = 16'd964;
        cal_k1 = 32'sd7793308;  cal_k2 = -32'sd2588698;
        cal_k3 = 32'sd4284897;  cal_k4 = -32'sd1590189;

        // Centre pixel gives the range on the axis, clipped above 32767
        add_row(16'd1272, 16'd964, 16'd0,     1, 16'd0, 16'd0, 16'd0,     0);
        add_row(16'd1272, 16'd964, 16'd256,   1, 16'd0, 16'd0, 16'd256,   0);
        add_row(16'd1272, 16'd964, 16'd32767, 1, 16'd0, 16'd0, 16'd32767, 0);
        add_row(16'd1272, 16'd964, 16'd32768, 1, 16'd0, 16'd0, 16'd32767, 1);
        add_row(16'd1272, 16'd964, 16'hFFFF,  1, 16'd0, 16'd0, 16'd32767, 1);
        // Field extremes and off-centre points
        add_row(16'd0,    16'd0,    16'hFFFF, 0, '0, '0, '0, 0);
        add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, '0, '0, '0, 0);
        add_row(16'd0,    16'hFFFF, 16'd256,  0, '0, '0, '0, 0);
        add_row(16'hFFFF, 16'd0,    16'd256,  0, '0, '0, '0, 0);
        add_row(16'd1273, 16'd964,  16'd256,  0, '0, '0, '0, 0);
        add_row(16'd1272, 16'd965,  16'd512,  0, '0, '0, '0, 0);
        add_row(16'd2272, 16'd964,  16'd256,  0, '0, '0, '0, 0);
        add_row(16'd1272, 16'd0,    16'd256,  0, '0, '0, '0, 0);
        add_row(16'd2000, 16'd2000, 16'd1000, 0, '0, '0, '0, 0);
        add_row(16'd500,  16'd1800, 16'd4000, 0, '0, '0, '0, 0);
        add_row(16'hAAAA, 16'h5555, 16'hAAAA, 0, '0, '0, '0, 0);
        add_row(16'h5555, 16'hAAAA, 16'h5555, 0, '0, '0, '0, 0);
        add_row(16'd1272, 16'd2564, 16'd0,    0, '0, '0, '0, 0);
        add_row(16'd3500, 16'd964,  16'd9000, 0, '0, '0, '0, 0);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Power-on calibration: table, then random pixels
        foreach (dir_rows[i]) send_pixel(dir_rows[i]);
        run_random(ITEMS_PHASE, 3000);
        wait_idle();

        // Zero focal lengths and zero distortion: coordinates clip
        load_cal(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        idle_mode = IDLE_NONE;
        send_pixel('{16'd0, 16'd0, 16'd256, 1'b1, '{16'd0, 16'd0, 16'd256, 1'b0}});
        run_random(100, 200);
        wait_idle();

        // Largest focal lengths and centre, largest positive coefficients
        load_cal(32'hFFFFF, 32'hFFFFF, 32'hFFFF, 32'hFFFF,
                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        run_random(ITEMS_PHASE, 30000);
        wait_idle();

        // Short focal lengths and most negative coefficients: steep angles
        load_cal(32'd9000, 32'd12000, 32'd20000, 32'd15000,
                 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        run_random(ITEMS_PHASE, 4000);
        wait_idle();

        // Random calibrations with moderate distortion
        for (int p = 0; p < 3; p++) begin
            load_cal($urandom_range(40000, 4000), $urandom_range(40000, 4000),
                     $urandom, $urandom,
                     32'($signed($urandom_range(32'h0FFFFFFF)) - 32'sh08000000),
                     32'($signed($urandom_range(32'h03FFFFFF)) - 32'sh02000000),
                     32'($signed($urandom_range(32'h03FFFFFF)) - 32'sh02000000),
                     32'($signed($urandom_range(32'h03FFFFFF)) - 32'sh02000000));
            run_random(130, 4000);
            wait_idle();
        end

        // Back to the power-on calibration
        load_cal(32'd18074, 32'd18074, 32'd1272, 32'd964,
                 32'd7793308, -32'sd2588698, 32'd4284897, -32'sd1590189);
        run_random(ITEMS_PHASE, 3000);
        wait_idle();

        $display("Checked %0d back-projected points over seven calibrations,", points_seen);
        $display("with sender gaps and receiver stalls mixed in; %0d field errors.", errors);
        if (errors == 0) begin
            $display("fisheye_point_backprojection: match");
        end else begin
            $display("fisheye_point_backprojection: mismatch");
        end
        $finish;
    end

endmodule
